// ===== rtl/scdp_pkg.sv =====
package scdp_pkg;

  // Fixed field widths
  localparam int ENERGY_W   = 12;
  localparam int COST_OUT_W = 24;
  localparam int CFG_W      = 11;

  // Width register value after reset
  localparam int CFG_WIDTH_RST = 1024;

  // Per-pixel control carried with a request into the cost stage
  typedef struct packed {
    logic first;    // pixel lies in the first row of the frame
    logic last;     // pixel is the last column of its row
    logic has_left; // column above-left exists (column > 0)
  } pix_ctl_t;

endpackage

// ===== rtl/scdp_if.sv =====
// Pixel energy request channel
interface scdp_in_if
  import scdp_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic                frame_start;

  modport source (output valid, output energy, output frame_start, input ready);
  modport sink   (input valid, input energy, input frame_start, output ready);
endinterface

// Seam cost result channel
interface scdp_out_if
  import scdp_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [COST_OUT_W-1:0] cost;
  logic                  row_end;

  modport source (output valid, output cost, output row_end, input ready);
  modport sink   (input valid, input cost, input row_end, output ready);
endinterface

// ===== rtl/scdp_linebuf.sv =====
// Previous-row cost buffer: one write port, two registered read ports.
// A read at the address written on the same edge returns the new data.
module scdp_linebuf
  import scdp_pkg::*;
#(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 24,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr0,
  input  logic [ADDR_W-1:0] rd_addr1,
  output logic [DATA_W-1:0] rd_data0,
  output logic [DATA_W-1:0] rd_data1,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] q0_r, q1_r;
  logic [DATA_W-1:0] byp_data_r;
  logic              byp0_r, byp1_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, held between requests
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q0_r       <= mem[rd_addr0];
      q1_r       <= mem[rd_addr1];
      byp0_r     <= wr_en && (wr_addr == rd_addr0);
      byp1_r     <= wr_en && (wr_addr == rd_addr1);
      byp_data_r <= wr_data;
    end
  end

  assign rd_data0 = byp0_r ? byp_data_r : q0_r;
  assign rd_data1 = byp1_r ? byp_data_r : q1_r;

endmodule

// ===== rtl/scdp_cost.sv =====
// Min of the up to three upper neighbors, add energy, saturate.
module scdp_cost
  import scdp_pkg::*;
#(
  parameter int COST_BITS = 24
) (
  input  pix_ctl_t             ctl,
  input  logic [ENERGY_W-1:0]  energy,
  input  logic [COST_BITS-1:0] left_cost,
  input  logic [COST_BITS-1:0] centre_cost,
  input  logic [COST_BITS-1:0] right_cost,
  output logic [COST_BITS-1:0] cost_sat
);

  logic [COST_BITS-1:0] best_lc;
  logic [COST_BITS-1:0] best;
  logic [COST_BITS:0]   sum;

  // neighbor selection, edges drop the missing side
  always_comb begin
    best_lc = (ctl.has_left && (left_cost < centre_cost)) ? left_cost : centre_cost;
    best    = (!ctl.last && (right_cost < best_lc)) ? right_cost : best_lc;
  end

  // accumulate and clamp at the largest cost
  always_comb begin
    if (ctl.first) begin
      sum = (COST_BITS+1)'(energy);
    end else begin
      sum = {1'b0, best} + (COST_BITS+1)'(energy);
    end
    cost_sat = sum[COST_BITS] ? {COST_BITS{1'b1}} : sum[COST_BITS-1:0];
  end

endmodule

// ===== rtl/seam_cost_dp.sv =====
// Channel  | Dir | Payload                         | Handshake
// in_ch    | in  | energy[11:0], frame_start       | valid/ready
// out_ch   | out | cost[23:0], row_end             | valid/ready
// cfg      | in  | cfg_wdata[10:0] (frame width)   | cfg_we, no wait
//
// One pixel per cycle unless out_ch stalls; cost stage then result register.
// The line buffer is read on the accept edge and written when the pixel
// leaves the cost stage; a same-edge read of the written column is bypassed.
// Reset (rst_n low, synchronous) starts a new frame at width 1024 (clamped
// to MAX_WIDTH); the buffer needs no clearing, the first row never reads it.
// A stalled output holds the cost stage; input is taken whenever it can move.
module seam_cost_dp
  import scdp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int COST_BITS = 24
) (
  input  logic              clk,
  input  logic              rst_n,
  scdp_in_if.sink           in_ch,
  scdp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W   = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
  localparam int RST_WID = (CFG_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : CFG_WIDTH_RST;
  localparam int EXT_W   = COST_BITS + COST_OUT_W;

  // column / row tracking
  logic [COL_W-1:0]    col_r, col_nxt;
  logic                first_r, first_nxt;
  logic [COL_W-1:0]    last_col_r, last_col_nxt;
  logic [CMP_W-1:0]    cfg_w;

  // accept-side decode
  logic                in_fire;
  logic [COL_W-1:0]    cur_col;
  pix_ctl_t            cur_ctl;

  // cost stage
  logic                s1_valid_r;
  logic                s1_fire;
  pix_ctl_t            s1_ctl_r;
  logic [COL_W-1:0]    s1_col_r;
  logic [ENERGY_W-1:0] s1_energy_r;
  logic [COST_BITS-1:0] left_r;
  logic [COST_BITS-1:0] centre_c, right_c;
  logic [COST_BITS-1:0] cost_sat;
  logic [EXT_W-1:0]    cost_ext;

  // result register
  logic                  out_valid_r;
  logic [COST_OUT_W-1:0] out_cost_r;
  logic                  out_row_end_r;

  // handshakes
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // column of the incoming pixel
  always_comb begin
    cur_col          = in_ch.frame_start ? '0 : col_r;
    cur_ctl.first    = in_ch.frame_start || first_r;
    cur_ctl.last     = (cur_col == last_col_r);
    cur_ctl.has_left = (cur_col != '0);
  end

  // clamp of a written width, kept as last column index
  always_comb begin
    cfg_w = CMP_W'(cfg_wdata);
    if (cfg_w < CMP_W'(2)) begin
      cfg_w = CMP_W'(2);
    end
    if (cfg_w > CMP_W'(MAX_WIDTH)) begin
      cfg_w = CMP_W'(MAX_WIDTH);
    end
    last_col_nxt = COL_W'(cfg_w - CMP_W'(1));
  end

  // next column state
  always_comb begin
    col_nxt   = col_r;
    first_nxt = first_r;
    if (cfg_we) begin
      col_nxt   = '0;
      first_nxt = 1'b1;
    end else if (in_fire) begin
      if (cur_ctl.last) begin
        col_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = cur_col + COL_W'(1);
        first_nxt = cur_ctl.first;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      first_r    <= 1'b1;
      last_col_r <= COL_W'(RST_WID - 1);
    end else begin
      col_r   <= col_nxt;
      first_r <= first_nxt;
      if (cfg_we) begin
        last_col_r <= last_col_nxt;
      end
    end
  end

  // previous-row costs
  scdp_linebuf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (COST_BITS),
    .ADDR_W (COL_W)
  ) u_linebuf (
    .clk      (clk),
    .rd_en    (in_fire),
    .rd_addr0 (cur_col),
    .rd_addr1 (cur_ctl.last ? cur_col : cur_col + COL_W'(1)),
    .rd_data0 (centre_c),
    .rd_data1 (right_c),
    .wr_en    (s1_fire),
    .wr_addr  (s1_col_r),
    .wr_data  (cost_sat)
  );

  // cost stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ctl_r    <= cur_ctl;
      s1_col_r    <= cur_col;
      s1_energy_r <= in_ch.energy;
    end
  end

  // above-left cost is the centre seen by the previous pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_fire) begin
      left_r <= centre_c;
    end
  end

  scdp_cost #(
    .COST_BITS (COST_BITS)
  ) u_cost (
    .ctl         (s1_ctl_r),
    .energy      (s1_energy_r),
    .left_cost   (left_r),
    .centre_cost (centre_c),
    .right_cost  (right_c),
    .cost_sat    (cost_sat)
  );

  assign cost_ext = EXT_W'(cost_sat);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cost_r    <= cost_ext[COST_OUT_W-1:0];
      out_row_end_r <= s1_ctl_r.last;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.cost    = out_cost_r;
  assign out_ch.row_end = out_row_end_r;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while cost stage is blocked");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && cur_ctl.last && !cfg_we) |=> (col_r == '0 && !first_r))
    else $error("column did not wrap at row end");

  a_first_row_cost: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_ctl_r.first) |=>
      (out_cost_r == COST_OUT_W'($past(s1_energy_r))))
    else $error("first-row cost differs from energy");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_cost_r)))
    else $error("stalled result changed");

endmodule

// ===== tb/sv/seam_cost_dp_check.sv =====
`timescale 1ns / 100ps

// Watches the request and result channels of seam_cost_dp, predicts each
// result from the accepted requests and compares, in order.
module seam_cost_dp_check
  import scdp_pkg::*;
#(
  parameter int MAX_W = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  scdp_in_if               in_ch,
  scdp_out_if              out_ch,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [COST_OUT_W-1:0] cost;
    logic                  row_end;
  } seam_result_t;

  localparam int unsigned COST_SAT = (1 << COST_OUT_W) - 1;

  // Shadow of the block's state
  logic [COST_OUT_W-1:0] line_costs [MAX_W];
  logic [CFG_W-1:0]      width_reg;
  int unsigned           col;
  bit                    in_top_row;
  logic [COST_OUT_W-1:0] above_left;

  seam_result_t cost_expect_q[$];
  int           mismatches = 0;

  task automatic clear_state();
    for (int i = 0; i < MAX_W; i++) line_costs[i] = '0;
    width_reg  = CFG_W'(CFG_WIDTH_RST);
    col        = 0;
    in_top_row = 1'b1;
    above_left = '0;
    cost_expect_q.delete();
  endtask

  // One pixel through the cost recurrence; queues the cost it must give.
  task automatic predict_seam_cost(input logic [ENERGY_W-1:0] energy, input logic fs);
    int unsigned           span;
    logic [COST_OUT_W-1:0] centre;
    logic [COST_OUT_W-1:0] best;
    int unsigned           sum;
    bit                    last;
    seam_result_t          res;
    span = (width_reg < 2) ? 2 : (width_reg > MAX_W) ? MAX_W : width_reg;
    if (fs) begin
      col        = 0;
      in_top_row = 1'b1;
    end
    if (col >= span) col = 0;
    last = (col == span - 1);
    if (in_top_row) begin
      sum        = 32'(energy);
      above_left = '0;
    end else begin
      centre = line_costs[col];
      best   = centre;
      if (col > 0 && above_left < best) best = above_left;
      if (!last && line_costs[col + 1] < best) best = line_costs[col + 1];
      sum        = 32'(energy) + 32'(best);
      above_left = centre;
    end
    if (sum > COST_SAT) sum = COST_SAT;
    line_costs[col] = sum[COST_OUT_W-1:0];
    if (last) begin
      col        = 0;
      in_top_row = 1'b0;
      above_left = '0;
    end else begin
      col = col + 1;
    end
    res.cost    = sum[COST_OUT_W-1:0];
    res.row_end = last;
    cost_expect_q.push_back(res);
  endtask

  always @(posedge clk) begin
    seam_result_t want;
    if (!rst_n) begin
      clear_state();
    end else begin
      // width write restarts the frame
      if (cfg_we) begin
        width_reg  = cfg_wdata;
        col        = 0;
        in_top_row = 1'b1;
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        predict_seam_cost(in_ch.energy, in_ch.frame_start);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (cost_expect_q.size() == 0) begin
          $error("result with no request waiting: cost %0d row_end %0b",
                 out_ch.cost, out_ch.row_end);
          mismatches++;
        end else begin
          want = cost_expect_q.pop_front();
          if (out_ch.cost !== want.cost) begin
            $error("cost: expected %0d, actual %0d", want.cost, out_ch.cost);
            mismatches++;
          end
          if (out_ch.row_end !== want.row_end) begin
            $error("row_end: expected %0b, actual %0b", want.row_end, out_ch.row_end);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= cost_expect_q.size();
  end

endmodule

// ===== tb/sv/seam_cost_dp_test.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for seam_cost_dp; checking lives in seam_cost_dp_check.
module seam_cost_dp_test
  import scdp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 180;
  localparam int QUIET_AFTER  = 120;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               check_fails;
  int               check_pending;
  int               cycle_count;
  int               stall_left;
  bit               quiet;

  scdp_in_if  in_if ();
  scdp_out_if out_if ();

  seam_cost_dp dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  seam_cost_dp_check cost_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fail_count(check_fails),
    .pending   (check_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("seam_cost_dp verification failed");
    $finish;
  end

  // Result side: ready drops in short bursts until the quiet tail
  initial begin
    out_if.ready = 1'b1;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_if.ready = 1'b0;
        stall_left   = $urandom_range(1, 3) - 1;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [ENERGY_W-1:0] pick_energy();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2, 3:    return '1;
      default: return ENERGY_W'($urandom_range(0, (1 << ENERGY_W) - 1));
    endcase
  endfunction

  // One pixel request; returns at the edge that accepts it, valid left high
  task automatic send_pixel(input logic [ENERGY_W-1:0] e, input logic fs);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.energy      = e;
    in_if.frame_start = fs;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
  endtask

  // Stop requests and wait until every result is back, then the pipe latency
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (check_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_W-1:0] w);
    wait_drained();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = w;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  initial begin
    int random_sent;
    int w;
    int span;
    int rows;
    int break_at;
    int drain_at;
    int sel;
    bit first_frame;
    bit fs;

    quiet             = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.energy      = '0;
    in_if.frame_start = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: three columns, edges use two neighbours
    set_width(3);
    send_pixel(0, 1'b1);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(7, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(0, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(12, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    // frame start in the middle of a row
    send_pixel(100, 1'b1);
    send_pixel(1, 1'b0);
    send_pixel(2, 1'b0);
    send_pixel(3, 1'b0);
    send_pixel(4, 1'b0);
    // width written mid-row restarts the frame; 0 and 1 act as 2
    set_width(0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(0, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(5, 1'b0);
    set_width(1);
    send_pixel(9, 1'b1);
    send_pixel(0, 1'b0);
    send_pixel(12'hFFF, 1'b0);
    send_pixel(1, 1'b0);

    // Widest rows: above-range value clamps to 1024, then a bit of row two
    set_width(11'h7FF);
    for (int k = 0; k < 1024 + 6; k++) send_pixel(pick_energy(), 1'b0);
    set_width(1024);
    for (int k = 0; k < 20; k++) send_pixel(pick_energy(), k == 0);

    // Random frames, mostly small widths
    random_sent = 0;
    first_frame = 1'b1;
    while (random_sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel < 14) w = $urandom_range(2, 12);
      else if (sel < 17) w = $urandom_range(13, 64);
      else w = $urandom_range(0, 3);
      set_width(CFG_W'(w));
      span = (w < 2) ? 2 : w;
      repeat ($urandom_range(1, 3)) begin
        rows     = $urandom_range(1, 6);
        break_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, rows * span - 1) : -1;
        drain_at = (first_frame || $urandom_range(0, 7) == 0) ?
                   $urandom_range(0, rows * span - 1) : -1;
        first_frame = 1'b0;
        for (int k = 0; k < rows * span && random_sent < RANDOM_ITEMS; k++) begin
          fs = (k == 0 && $urandom_range(0, 9) != 0) || k == break_at ||
               $urandom_range(0, 39) == 0;
          // sender holds off until the block has emptied
          if (k == drain_at) wait_drained();
          send_pixel(pick_energy(), fs);
          random_sent++;
          if (random_sent >= QUIET_AFTER) quiet = 1'b1;
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (check_fails == 0 && check_pending == 0) begin
      $display("seam_cost_dp verification clean");
    end else begin
      $display("seam_cost_dp verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/scdp_pkg.sv
rtl/scdp_if.sv
rtl/scdp_linebuf.sv
rtl/scdp_cost.sv
rtl/seam_cost_dp.sv
tb/sv/seam_cost_dp_check.sv
tb/sv/seam_cost_dp_test.sv
